/* src/pingpong_compare_schedule_feeder_core_assert.svh */
// Assertion macros shared by the feeder's checker.
`ifndef PINGPONG_COMPARE_SCHEDULE_FEEDER_CORE_ASSERT_SVH
`define PINGPONG_COMPARE_SCHEDULE_FEEDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPCSF_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ppcsf checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPCSF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ppcsf checker: next-cycle property failed");

`endif

/* src/ppcsf_pkg.sv */
// Shared constants, codes and word types of the compare schedule feeder.
package ppcsf_pkg;

    localparam int MAX_BUFFER = 256;
    localparam int LEN_W      = 9;
    localparam int HALF_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int VALUE_W    = 16;
    localparam int DIV_STEPS  = COUNT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_BUFFER);
    localparam logic [VALUE_W-1:0] DELAY_MAX = 16'hFFFF;

    // Operation codes
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STEP     = 3'd1;
    localparam logic [2:0] OP_HALF     = 3'd2;
    localparam logic [2:0] OP_COMPLETE = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;

    // Pending half codes
    localparam logic [1:0] PEND_H0   = 2'd0;
    localparam logic [1:0] PEND_H1   = 2'd1;
    localparam logic [1:0] PEND_NONE = 2'd2;

    typedef struct packed {
        logic [2:0]          operation;
        logic signed [31:0]  delay_ticks;
        logic [15:0]         remaining_in_round;
    } cmd_word_t;

    typedef struct packed {
        logic                value_valid;
        logic [7:0]          buffer_index;
        logic [15:0]         compare_value;
        logic                half_complete;
        logic                underrun;
        logic                finished;
        logic [31:0]         sent_count;
        logic [31:0]         remaining_count;
        logic [8:0]          buffer_size_used;
    } res_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic long_start;
        logic div_done;
    } ctrl_status_t;

endpackage

/* src/pingpong_compare_schedule_feeder_core.sv */
// Top level of the ping-pong compare schedule feeder.
//
// Channels: cmd (cmd_valid/cmd_ready/cmd_word) takes one word per item,
// res (res_valid/res_ready/res_word) gives exactly one word per item, and
// cfg (cfg_valid/cfg_ready/cfg_data) writes the total count; cfg_ready is
// always high. Write the total count only while no item is in flight.
// The result word is registered: the item is accepted, then committed
// into the output register. A new item is taken only after the last commits.
// Start with a total count above 256 runs the divisor search before the
// commit: a bit-serial remainder unit tests each candidate, from 256 down.
// The result sits in an output register; a new item is taken while it
// waits, but that item's commit holds until the waiting word is taken.
// Reset (rst_n, asynchronous, active low) clears the feeder state, sets
// the total count to 1, no half pending, and drops res_valid.
module pingpong_compare_schedule_feeder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ppcsf_pkg::cmd_word_t          cmd_word,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ppcsf_pkg::res_word_t          res_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppcsf_pkg::COUNT_W-1:0] cfg_data
);

    ppcsf_pkg::ctrl_cmd_t    ctl_cmd;
    ppcsf_pkg::ctrl_status_t ctl_status;

    assign cfg_ready = 1'b1;

    ppcsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (ctl_status),
        .cmd       (ctl_cmd)
    );

    ppcsf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (ctl_cmd),
        .status    (ctl_status),
        .res_word  (res_word)
    );

endmodule

/* src/ppcsf_div.sv */
// Divisor search: largest divisor of the total count not above the buffer limit.
module ppcsf_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ppcsf_pkg::COUNT_W-1:0]    dividend,
    output logic                             done,
    output logic [ppcsf_pkg::LEN_W-1:0]      result
);

    logic [ppcsf_pkg::LEN_W-1:0]     cand_reg, cand_next;
    logic [ppcsf_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic [ppcsf_pkg::COUNT_W-1:0]   shift_reg, shift_next;
    logic [ppcsf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [ppcsf_pkg::LEN_W-1:0]     result_reg, result_next;
    logic [ppcsf_pkg::LEN_W:0]       trial;
    logic [ppcsf_pkg::LEN_W-1:0]     rem_step;

    // One restoring remainder bit per cycle
    always_comb
    begin
        trial = {rem_reg, shift_reg[ppcsf_pkg::COUNT_W-1]};
        if (trial >= {1'b0, cand_reg})
            rem_step = ppcsf_pkg::LEN_W'(trial - {1'b0, cand_reg});
        else
            rem_step = trial[ppcsf_pkg::LEN_W-1:0];
    end

    // Candidate walk: test one candidate at a time, count down on a miss
    always_comb
    begin
        cand_next   = cand_reg;
        rem_next    = rem_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (start)
        begin
            cand_next  = ppcsf_pkg::MAX_LEN;
            rem_next   = '0;
            shift_next = dividend;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = rem_step;
            shift_next = {shift_reg[ppcsf_pkg::COUNT_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == ppcsf_pkg::DIV_CNT_W'(ppcsf_pkg::DIV_STEPS - 1))
            begin
                if (rem_step == '0)
                begin
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    result_next = cand_reg;
                end
                else if (cand_reg == ppcsf_pkg::LEN_W'(2))
                begin
                    // nothing above one divides: length one
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    result_next = ppcsf_pkg::LEN_W'(1);
                end
                else
                begin
                    cand_next  = cand_reg - 1'b1;
                    rem_next   = '0;
                    shift_next = dividend;
                    cnt_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        rem_reg    <= rem_next;
        shift_reg  <= shift_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/ppcsf_dp.sv */
// Datapath: feeder state, item staging, state update and result word register.
module ppcsf_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ppcsf_pkg::cmd_word_t             cmd_word,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ppcsf_pkg::COUNT_W-1:0]    cfg_data,
    input  ppcsf_pkg::ctrl_cmd_t             cmd,
    output ppcsf_pkg::ctrl_status_t          status,
    output ppcsf_pkg::res_word_t             res_word
);

    // Configuration and feeder state
    logic [ppcsf_pkg::COUNT_W-1:0] total_reg;
    logic [ppcsf_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [ppcsf_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                          active_reg, active_next;
    logic                          h0_reg, h0_next;
    logic                          h1_reg, h1_next;
    logic [1:0]                    pend_reg, pend_next;
    logic                          sfp_reg, sfp_next;
    logic [ppcsf_pkg::HALF_W-1:0]  fill_reg, fill_next;
    logic [ppcsf_pkg::COUNT_W-1:0] xfer_reg, xfer_next;

    // Staged item
    logic [2:0]                    op_reg;
    logic [ppcsf_pkg::VALUE_W-1:0] delay_reg, delay_next;
    logic [ppcsf_pkg::COUNT_W:0]   sum_reg, sum_next;
    ppcsf_pkg::res_word_t          res_reg, res_next;

    logic                          div_done;
    logic [ppcsf_pkg::LEN_W-1:0]   div_result;
    logic [ppcsf_pkg::LEN_W-1:0]   in_round;
    logic [ppcsf_pkg::LEN_W-1:0]   new_len;
    logic [ppcsf_pkg::HALF_W-1:0]  half_slots;
    logic [ppcsf_pkg::HALF_W-1:0]  fill_inc;
    logic [ppcsf_pkg::COUNT_W-1:0] sent;
    logic [ppcsf_pkg::COUNT_W:0]   rem_diff;
    logic                          long_total;

    ppcsf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .done     (div_done),
        .result   (div_result)
    );

    assign long_total        = (total_reg > ppcsf_pkg::COUNT_W'(ppcsf_pkg::MAX_BUFFER));
    assign status.long_start = (cmd_word.operation == ppcsf_pkg::OP_START) && long_total;
    assign status.div_done   = div_done;

    // Load stage: clamp the delay and form the running-count sum
    always_comb
    begin
        if (cmd_word.delay_ticks[31])
            delay_next = '0;
        else if (|cmd_word.delay_ticks[30:16])
            delay_next = ppcsf_pkg::DELAY_MAX;
        else
            delay_next = cmd_word.delay_ticks[15:0];

        if ({7'b0, len_reg} >= cmd_word.remaining_in_round)
            in_round = len_reg - cmd_word.remaining_in_round[ppcsf_pkg::LEN_W-1:0];
        else
            in_round = '0;

        if (cmd_word.operation == ppcsf_pkg::OP_QUERY)
            sum_next = {1'b0, xfer_reg} + (ppcsf_pkg::COUNT_W + 1)'(in_round);
        else
            sum_next = {1'b0, xfer_reg} + (ppcsf_pkg::COUNT_W + 1)'(len_reg);
    end

    // Commit stage: state update and result word
    always_comb
    begin
        acc_next    = acc_reg;
        len_next    = len_reg;
        active_next = active_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        pend_next   = pend_reg;
        sfp_next    = sfp_reg;
        fill_next   = fill_reg;
        xfer_next   = xfer_reg;
        res_next    = '0;

        half_slots = len_reg[ppcsf_pkg::LEN_W-1:1];
        fill_inc   = fill_reg + 1'b1;
        new_len    = long_total ? div_result : total_reg[ppcsf_pkg::LEN_W-1:0];
        sent       = sum_reg[ppcsf_pkg::COUNT_W] ? '1 : sum_reg[ppcsf_pkg::COUNT_W-1:0];
        rem_diff   = {1'b0, total_reg} - {1'b0, sent};

        case (op_reg)
            ppcsf_pkg::OP_START:
            begin
                len_next    = new_len;
                active_next = 1'b0;
                xfer_next   = '0;
                fill_next   = '0;
                if (new_len[ppcsf_pkg::LEN_W-1:1] == '0)
                begin
                    // halves without slots count as filled at once (the second only for a nonzero total)
                    h0_next   = 1'b1;
                    h1_next   = (total_reg != '0);
                    pend_next = ppcsf_pkg::PEND_NONE;
                    sfp_next  = 1'b0;
                end
                else
                begin
                    h0_next   = 1'b0;
                    h1_next   = 1'b0;
                    pend_next = ppcsf_pkg::PEND_H0;
                    sfp_next  = 1'b1;
                end
            end
            ppcsf_pkg::OP_STEP:
            begin
                if ((pend_reg != ppcsf_pkg::PEND_NONE) &&
                    (sfp_reg || (xfer_reg < total_reg)))
                begin
                    if (half_slots == '0)
                    begin
                        if (pend_reg == ppcsf_pkg::PEND_H0)
                            h0_next = 1'b1;
                        else
                            h1_next = 1'b1;
                        pend_next = ppcsf_pkg::PEND_NONE;
                        fill_next = '0;
                        sfp_next  = 1'b0;
                    end
                    else
                    begin
                        acc_next               = acc_reg + delay_reg;
                        res_next.value_valid   = 1'b1;
                        res_next.buffer_index  = (pend_reg == ppcsf_pkg::PEND_H1) ?
                                                 (half_slots + fill_reg) : fill_reg;
                        res_next.compare_value = acc_reg + delay_reg;
                        fill_next              = fill_inc;
                        if (fill_inc >= half_slots)
                        begin
                            res_next.half_complete = 1'b1;
                            if (pend_reg == ppcsf_pkg::PEND_H0)
                                h0_next = 1'b1;
                            else
                                h1_next = 1'b1;
                            fill_next = '0;
                            if (sfp_reg && (pend_reg == ppcsf_pkg::PEND_H0) &&
                                (total_reg > ppcsf_pkg::COUNT_W'(half_slots)))
                            begin
                                pend_next = ppcsf_pkg::PEND_H1;
                            end
                            else
                            begin
                                pend_next = ppcsf_pkg::PEND_NONE;
                                sfp_next  = 1'b0;
                            end
                        end
                    end
                end
            end
            ppcsf_pkg::OP_HALF, ppcsf_pkg::OP_COMPLETE:
            begin
                if ((op_reg == ppcsf_pkg::OP_COMPLETE) &&
                    (sum_reg >= {1'b0, total_reg}))
                begin
                    xfer_next         = total_reg;
                    res_next.finished = 1'b1;
                end
                else
                begin
                    if (op_reg == ppcsf_pkg::OP_COMPLETE)
                        xfer_next = sum_reg[ppcsf_pkg::COUNT_W-1:0];
                    // swap halves
                    fill_next = '0;
                    sfp_next  = 1'b0;
                    if (!active_reg)
                    begin
                        active_next       = 1'b1;
                        h0_next           = 1'b0;
                        res_next.underrun = !h1_reg;
                        pend_next         = ppcsf_pkg::PEND_H0;
                    end
                    else
                    begin
                        active_next       = 1'b0;
                        h1_next           = 1'b0;
                        res_next.underrun = !h0_reg;
                        pend_next         = ppcsf_pkg::PEND_H1;
                    end
                end
            end
            ppcsf_pkg::OP_QUERY:
            begin
                res_next.sent_count      = sent;
                res_next.remaining_count = rem_diff[ppcsf_pkg::COUNT_W] ?
                                           '0 : rem_diff[ppcsf_pkg::COUNT_W-1:0];
            end
            default:
            begin
                res_next = '0;
            end
        endcase
        res_next.buffer_size_used = len_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= ppcsf_pkg::COUNT_W'(1);
            acc_reg    <= '0;
            len_reg    <= '0;
            active_reg <= 1'b0;
            h0_reg     <= 1'b0;
            h1_reg     <= 1'b0;
            pend_reg   <= ppcsf_pkg::PEND_NONE;
            sfp_reg    <= 1'b0;
            fill_reg   <= '0;
            xfer_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                total_reg <= cfg_data;
            if (cmd.commit)
            begin
                acc_reg    <= acc_next;
                len_reg    <= len_next;
                active_reg <= active_next;
                h0_reg     <= h0_next;
                h1_reg     <= h1_next;
                pend_reg   <= pend_next;
                sfp_reg    <= sfp_next;
                fill_reg   <= fill_next;
                xfer_reg   <= xfer_next;
            end
        end
    end

    // Staged item and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= cmd_word.operation;
            delay_reg <= delay_next;
            sum_reg   <= sum_next;
        end
        if (cmd.commit)
            res_reg <= res_next;
    end

    assign res_word = res_reg;

endmodule

/* src/ppcsf_ctrl.sv */
// Controller: sequences accept, divisor search and commit of each word.
module ppcsf_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    output logic                     res_valid,
    input  logic                     res_ready,
    input  ppcsf_pkg::ctrl_status_t  status,
    output ppcsf_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } state_t;

    state_t state_reg;
    logic   res_valid_reg;
    logic   accept;
    logic   slot_free;

    assign cmd_ready     = (state_reg == S_IDLE);
    assign accept        = cmd_valid && cmd_ready;
    assign slot_free     = !res_valid_reg || res_ready;

    assign cmd.load      = accept;
    assign cmd.div_start = accept && status.long_start;
    assign cmd.commit    = (state_reg == S_COMMIT) && slot_free;
    assign res_valid     = res_valid_reg;

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= status.long_start ? S_SEARCH : S_COMMIT;
                end
                S_SEARCH:
                begin
                    if (status.div_done)
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.commit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

endmodule

/* src/ppcsf_checker.sv */
// Port-level checker of the feeder, bound to the top level.
`include "pingpong_compare_schedule_feeder_core_assert.svh"

module ppcsf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  ppcsf_pkg::res_word_t          res_word
);

    // A taken command word closes the input for at least the next cycle
    `PPCSF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // A stalled result word holds
    `PPCSF_ASSERT_NEXT(a_res_hold, clk, rst_n,
        res_valid && !res_ready, res_valid && $stable(res_word))

    // Buffer length never exceeds the limit
    `PPCSF_ASSERT_SAME(a_len_limit, clk, rst_n,
        res_valid, res_word.buffer_size_used <= ppcsf_pkg::MAX_LEN)

    // A written value never comes with swap or end-of-run flags
    `PPCSF_ASSERT_SAME(a_value_excl, clk, rst_n,
        res_valid && res_word.value_valid, !res_word.underrun && !res_word.finished)

    // Half complete only on a written value
    `PPCSF_ASSERT_SAME(a_half_needs_value, clk, rst_n,
        res_valid && res_word.half_complete, res_word.value_valid)

endmodule

bind pingpong_compare_schedule_feeder_core ppcsf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
);
